>>> hw/rtl/kmh_pkg.sv
// shared types and constants for the k-way merge min-heap
package kmh_pkg;

   localparam int KEY_W        = 64;
   localparam int SRC_W        = 4;
   localparam int LIVE_W       = 5;
   localparam int NUM_WAYS_DEF = 16;
   localparam int KEY_BITS_DEF = 64;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/kmh_ram.sv
// generic single write port, single read port ram with registered read
module kmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/kway_merge_min_heap_top.sv
// k-way merge min-heap top level: heap memory, sift sequencer, result register
// each level an item moves costs a read state and a compare state (UP_RD/UP_CMP or
// DN_RD/DN_CMP); a refused insert or a pop of an empty root goes straight to ST_DONE
// requests stall while the sequencer is busy, so items go through one at a time
// the result register lets a new item enter while the last result waits
// reset clears the fill and live counts and the sequencer; the heap ram is not cleared
module kway_merge_min_heap_top #(
   parameter int NUM_WAYS = kmh_pkg::NUM_WAYS_DEF,
   parameter int KEY_BITS = kmh_pkg::KEY_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic [kmh_pkg::KEY_W-1:0]  req_key,
   input  logic [kmh_pkg::SRC_W-1:0]  req_source,
   input  logic                       req_has_next,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [kmh_pkg::KEY_W-1:0]  rsp_popped_key,
   output logic [kmh_pkg::SRC_W-1:0]  rsp_popped_source,
   output logic                       rsp_popped_valid,
   output logic [kmh_pkg::KEY_W-1:0]  rsp_head_key,
   output logic [kmh_pkg::SRC_W-1:0]  rsp_head_source,
   output logic                       rsp_head_valid,
   output logic [kmh_pkg::LIVE_W-1:0] rsp_live_sources
);

   import kmh_pkg::*;

   localparam int IDX_W = $clog2(NUM_WAYS);
   localparam int CNT_W = $clog2(NUM_WAYS + 1);
   localparam int CH_W  = IDX_W + 2;
   localparam int ENT_W = KEY_BITS + SRC_W + 1;
   localparam int SRC_LO = KEY_BITS;
   localparam int VLD_B  = ENT_W - 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [ENT_W-1:0] cur_ff, cur_in;
   logic [ENT_W-1:0] root_ff;

   logic [KEY_BITS-1:0] pop_key_ff, pop_key_in;
   logic [SRC_W-1:0]    pop_src_ff, pop_src_in;
   logic                pop_vld_ff, pop_vld_in;

   logic                rsp_valid_ff;
   logic [KEY_W-1:0]    rsp_pkey_ff, rsp_hkey_ff;
   logic [SRC_W-1:0]    rsp_psrc_ff, rsp_hsrc_ff;
   logic                rsp_pvld_ff, rsp_hvld_ff;
   logic [LIVE_W-1:0]   rsp_live_ff;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [ENT_W-1:0] wr_data, rd_a, rd_b;

   logic             req_acc, rsp_free, root_ok;
   logic [IDX_W-1:0] pos_m1, parent;
   logic [CH_W-1:0]  left, right, fill_x;
   logic             left_in, right_in;
   logic             lv, rv, pick_right, stop_dn, up_move;
   logic [ENT_W-1:0] pick_ent;
   logic [IDX_W-1:0] pick_idx;
   logic [KEY_W-1:0]       pkey_x, hkey_x;
   logic [CNT_W+LIVE_W-1:0] live_x;

   assign req_acc  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign root_ok  = (fill_ff != '0) && root_ff[VLD_B];

   assign pos_m1   = pos_ff - 1'b1;
   assign parent   = pos_m1 >> 1;
   assign left     = {1'b0, pos_ff, 1'b1};
   assign right    = left + 1'b1;
   assign fill_x   = CH_W'(fill_ff);
   assign left_in  = left < fill_x;
   assign right_in = right < fill_x;

   assign lv         = rd_a[VLD_B];
   assign rv         = right_in && rd_b[VLD_B];
   assign pick_right = (lv && rv) ? !(rd_a[KEY_BITS-1:0] < rd_b[KEY_BITS-1:0]) : rv;
   assign pick_ent   = pick_right ? rd_b : rd_a;
   assign pick_idx   = pick_right ? right[IDX_W-1:0] : left[IDX_W-1:0];
   assign stop_dn    = !(lv || rv) ||
                       (cur_ff[VLD_B] && (cur_ff[KEY_BITS-1:0] <= pick_ent[KEY_BITS-1:0]));
   assign up_move    = !rd_a[VLD_B] || (cur_ff[KEY_BITS-1:0] < rd_a[KEY_BITS-1:0]);

   kmh_ram #(.WIDTH(ENT_W), .DEPTH(NUM_WAYS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   kmh_ram #(.WIDTH(ENT_W), .DEPTH(NUM_WAYS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_operation == OP_INSERT) begin
                  state_in = (fill_ff < CNT_W'(NUM_WAYS)) ? ST_UP_RD : ST_DONE;
               end else begin
                  state_in = root_ok ? ST_DN_RD : ST_DONE;
               end
            end
         end
         ST_UP_RD:  state_in = (pos_ff == '0) ? ST_DONE : ST_UP_CMP;
         ST_UP_CMP: state_in = up_move ? ST_UP_RD : ST_DONE;
         ST_DN_RD:  state_in = left_in ? ST_DN_CMP : ST_DONE;
         ST_DN_CMP: state_in = stop_dn ? ST_DONE : ST_DN_RD;
         ST_DONE:   state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      fill_in    = fill_ff;
      live_in    = live_ff;
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      pop_key_in = pop_key_ff;
      pop_src_in = pop_src_ff;
      pop_vld_in = pop_vld_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = cur_ff;
      rd_en      = 1'b0;
      rd_addr_a  = parent;
      rd_addr_b  = parent;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               pop_key_in = '0;
               pop_src_in = '0;
               pop_vld_in = 1'b0;
               pos_in     = '0;
               if (req_operation == OP_INSERT) begin
                  cur_in = {1'b1, req_source, req_key[KEY_BITS-1:0]};
                  if (fill_ff < CNT_W'(NUM_WAYS)) begin
                     pos_in  = fill_ff[IDX_W-1:0];
                     fill_in = fill_ff + 1'b1;
                     live_in = live_ff + 1'b1;
                  end
               end else if (root_ok) begin
                  pop_key_in = root_ff[KEY_BITS-1:0];
                  pop_src_in = root_ff[SRC_LO +: SRC_W];
                  pop_vld_in = 1'b1;
                  if (req_has_next) begin
                     cur_in = {1'b1, root_ff[SRC_LO +: SRC_W], req_key[KEY_BITS-1:0]};
                  end else begin
                     cur_in = {1'b0, root_ff[SRC_LO +: SRC_W], root_ff[KEY_BITS-1:0]};
                     if (live_ff != '0) begin
                        live_in = live_ff - 1'b1;
                     end
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_en = 1'b1;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (up_move) begin
               wr_data = rd_a;
               pos_in  = parent;
            end
         end
         ST_DN_RD: begin
            rd_addr_a = left[IDX_W-1:0];
            rd_addr_b = right_in ? right[IDX_W-1:0] : left[IDX_W-1:0];
            if (left_in) begin
               rd_en = 1'b1;
            end else begin
               wr_en = 1'b1;
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (!stop_dn) begin
               wr_data = pick_ent;
               pos_in  = pick_idx;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pkey_x = '0;
      pkey_x[KEY_BITS-1:0] = pop_key_ff;
      hkey_x = '0;
      if (root_ok) begin
         hkey_x[KEY_BITS-1:0] = root_ff[KEY_BITS-1:0];
      end
      live_x = '0;
      live_x[CNT_W-1:0] = live_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         live_ff  <= live_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cur_ff     <= cur_in;
      pop_key_ff <= pop_key_in;
      pop_src_ff <= pop_src_in;
      pop_vld_ff <= pop_vld_in;
      // mirror of heap slot zero
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_pkey_ff <= pkey_x;
         rsp_psrc_ff <= pop_src_ff;
         rsp_pvld_ff <= pop_vld_ff;
         rsp_hkey_ff <= hkey_x;
         rsp_hsrc_ff <= root_ok ? root_ff[SRC_LO +: SRC_W] : '0;
         rsp_hvld_ff <= root_ok;
         rsp_live_ff <= live_x[LIVE_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_key    = rsp_pkey_ff;
   assign rsp_popped_source = rsp_psrc_ff;
   assign rsp_popped_valid  = rsp_pvld_ff;
   assign rsp_head_key      = rsp_hkey_ff;
   assign rsp_head_source   = rsp_hsrc_ff;
   assign rsp_head_valid    = rsp_hvld_ff;
   assign rsp_live_sources  = rsp_live_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(NUM_WAYS))
      else $error("heap fill count beyond capacity");

   a_live_le_fill: assert property (@(posedge clock) disable iff (reset)
      live_ff <= fill_ff)
      else $error("live count exceeds fill count");

   a_rd_wr_apart: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("heap ram read and write in the same cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_operation == OP_INSERT && fill_ff < CNT_W'(NUM_WAYS))
      |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("insert did not grow the heap");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not moved to the result register");

endmodule
